### hw/rtl/tsam_pkg.sv
// ----------------------------------------------------------------------------
// tsam_pkg
// Shared types and constants for the topological sort unit.
// ----------------------------------------------------------------------------
package tsam_pkg;

	// width of the vertex_count register
	localparam int VC_W = 6;
	// width of a vertex id on the ports
	localparam int VID_W = 5;
	// vertex_count after reset
	localparam logic [VC_W-1:0] VC_RESET = 6'd32;

	typedef enum logic [2:0] {
		S_LOAD,   // taking edges
		S_SWEEP,  // outer sweep over root vertices
		S_ROW,    // adjacency row read for stack top
		S_SCAN,   // pick lowest unvisited neighbor, push or pop
		S_POP,    // reload stack top from stack memory
		S_RD,     // order memory read
		S_OUT     // result held on output
	} state_t;

endpackage

### hw/rtl/tsam_pick.sv
// ----------------------------------------------------------------------------
// tsam_pick
// Lowest-set-bit finder: flags whether any candidate bit is set and gives
// the index of the lowest one.
// ----------------------------------------------------------------------------
module tsam_pick #(
	parameter int W = 32
) (
	input  logic [W-1:0]         cand,
	output logic                 hit,
	output logic [$clog2(W)-1:0] idx
);

	localparam int IW = $clog2(W);

	logic [W-1:0] iso;

	// isolate the lowest set bit, then encode the one-hot result
	assign iso = cand & (~cand + W'(1));
	assign hit = |cand;

	always_comb begin
		idx = '0;
		for (int i = 0; i < W; i++) begin
			if (iso[i]) begin
				idx = idx | IW'(i);
			end
		end
	end

endmodule

### hw/rtl/topo_sort_adjacency_matrix_unit.sv
// ----------------------------------------------------------------------------
// topo_sort_adjacency_matrix_unit
// Depth-first topological sort over an adjacency matrix held in memory.
// ----------------------------------------------------------------------------
// Edge transactions (from_vertex != to_vertex) are taken while loading and
// each one inside the graph sets one bit of the adjacency memory. A
// transaction with equal vertices closes loading and starts the search
// over n = vertex_count vertices (0 read as 1, clamped to MAX_VERTICES).
// The search is a small sequencer around a single lowest-unvisited-neighbor
// picker: a tree edge takes a registered adjacency row read and a scan, a
// finished vertex a scan and, unless it is a root, a stack pop and a row
// read. The n results then follow one at a time, each read from the order
// memory and held until taken, with last_of_order on the final one. No
// input transaction is taken from the closing edge until the final result
// is delivered; the matrix and visited marks then clear at once.
// ----------------------------------------------------------------------------
module topo_sort_adjacency_matrix_unit #(
	parameter int MAX_VERTICES = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [tsam_pkg::VC_W-1:0]   cfg_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [tsam_pkg::VID_W-1:0]  from_vertex,
	input  logic [tsam_pkg::VID_W-1:0]  to_vertex,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [tsam_pkg::VID_W-1:0]  vertex,
	output logic                        last_of_order
);

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);

	tsam_pkg::state_t state_q, state_d;

	logic [tsam_pkg::VC_W-1:0] vc_q;
	logic [CW-1:0]             n_use;
	logic [CW-1:0]             n_q;
	logic [MAX_VERTICES-1:0]   visited_q;
	logic [MAX_VERTICES-1:0]   row_vld_q;
	logic [CW-1:0]             depth_q;
	logic [CW-1:0]             fill_q;
	logic [CW-1:0]             sweep_q;
	logic [VW-1:0]             k_q;
	logic [VW-1:0]             top_q;

	logic [MAX_VERTICES-1:0]   adj_mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0]   adj_rd_q;
	logic                      adj_rd_vld_q;
	logic [VW-1:0]             stk_mem [MAX_VERTICES];
	logic [VW-1:0]             stk_rd_q;
	logic [VW-1:0]             ord_mem [MAX_VERTICES];
	logic [VW-1:0]             ord_rd_q;

	logic                      in_acc, out_acc, closing, edge_ok, is_last;
	logic [VW-1:0]             from_idx, to_idx, sweep_idx;
	logic [MAX_VERTICES-1:0]   to_oh, nmask, cand;
	logic                      pick_hit;
	logic [VW-1:0]             pick_idx;
	logic                      adj_we, stk_we, ord_we, can_push;

	// ---------------------------------------------------------------- decode
	assign in_acc    = in_valid & ~in_stall;
	assign out_acc   = out_valid & ~out_stall;
	assign closing   = (from_vertex == to_vertex);
	assign from_idx  = VW'(from_vertex);
	assign to_idx    = VW'(to_vertex);
	assign sweep_idx = sweep_q[VW-1:0];
	assign is_last   = ((CW'(k_q) + CW'(1)) == n_q);
	assign can_push  = (int'(depth_q) < MAX_VERTICES);

	always_comb begin
		if (vc_q == '0) begin
			n_use = CW'(1);
		end else if (int'(vc_q) > MAX_VERTICES) begin
			n_use = CW'(MAX_VERTICES);
		end else begin
			n_use = CW'(vc_q);
		end
	end

	assign edge_ok = (int'(from_vertex) < int'(n_use)) && (int'(to_vertex) < int'(n_use));

	always_comb begin
		for (int i = 0; i < MAX_VERTICES; i++) begin
			to_oh[i] = (to_idx == VW'(i));
			nmask[i] = (i < int'(n_q));
		end
	end

	// neighbors of the stack top that are still open and inside the graph
	assign cand = (adj_rd_vld_q ? adj_rd_q : '0) & ~visited_q & nmask;

	tsam_pick #(
		.W(MAX_VERTICES)
	) u_pick (
		.cand(cand),
		.hit (pick_hit),
		.idx (pick_idx)
	);

	assign adj_we = (state_q == tsam_pkg::S_LOAD) && in_acc && !closing && edge_ok;
	assign stk_we = (state_q == tsam_pkg::S_SCAN) && pick_hit && can_push;
	assign ord_we = (state_q == tsam_pkg::S_SCAN) && !pick_hit && (fill_q != '0);

	// ------------------------------------------------------------ next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tsam_pkg::S_LOAD: begin
				if (in_acc && closing) begin
					state_d = tsam_pkg::S_SWEEP;
				end
			end
			tsam_pkg::S_SWEEP: begin
				if (sweep_q == n_q) begin
					state_d = tsam_pkg::S_RD;
				end else if (!visited_q[sweep_idx]) begin
					state_d = tsam_pkg::S_ROW;
				end
			end
			tsam_pkg::S_ROW: begin
				state_d = tsam_pkg::S_SCAN;
			end
			tsam_pkg::S_SCAN: begin
				if (pick_hit) begin
					state_d = tsam_pkg::S_ROW;
				end else if (depth_q == CW'(1)) begin
					state_d = tsam_pkg::S_SWEEP;
				end else begin
					state_d = tsam_pkg::S_POP;
				end
			end
			tsam_pkg::S_POP: begin
				state_d = tsam_pkg::S_ROW;
			end
			tsam_pkg::S_RD: begin
				state_d = tsam_pkg::S_OUT;
			end
			tsam_pkg::S_OUT: begin
				if (out_acc) begin
					state_d = is_last ? tsam_pkg::S_LOAD : tsam_pkg::S_RD;
				end
			end
			default: begin
				state_d = tsam_pkg::S_LOAD;
			end
		endcase
	end

	// --------------------------------------------------------------- outputs
	always_comb begin
		cfg_ready     = 1'b1;
		in_stall      = (state_q != tsam_pkg::S_LOAD);
		out_valid     = (state_q == tsam_pkg::S_OUT);
		vertex        = tsam_pkg::VID_W'(ord_rd_q);
		last_of_order = is_last;
	end

	// ------------------------------------------------------- control/datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tsam_pkg::S_LOAD;
			vc_q      <= tsam_pkg::VC_RESET;
			n_q       <= CW'(1);
			visited_q <= '0;
			row_vld_q <= '0;
			depth_q   <= '0;
			fill_q    <= '0;
			sweep_q   <= '0;
			k_q       <= '0;
			top_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				vc_q <= cfg_data;
			end
			unique case (state_q)
				tsam_pkg::S_LOAD: begin
					if (in_acc) begin
						if (closing) begin
							n_q     <= n_use;
							fill_q  <= n_use;
							sweep_q <= '0;
							k_q     <= '0;
						end else if (edge_ok) begin
							row_vld_q[from_idx] <= 1'b1;
						end
					end
				end
				tsam_pkg::S_SWEEP: begin
					if (sweep_q != n_q) begin
						if (visited_q[sweep_idx]) begin
							sweep_q <= sweep_q + CW'(1);
						end else begin
							visited_q[sweep_idx] <= 1'b1;
							top_q                <= sweep_idx;
							depth_q              <= CW'(1);
						end
					end
				end
				tsam_pkg::S_SCAN: begin
					if (pick_hit) begin
						visited_q[pick_idx] <= 1'b1;
						if (can_push) begin
							top_q   <= pick_idx;
							depth_q <= depth_q + CW'(1);
						end
					end else begin
						// top vertex finished: pop it into the order store
						depth_q <= depth_q - CW'(1);
						if (fill_q != '0) begin
							fill_q <= fill_q - CW'(1);
						end
					end
				end
				tsam_pkg::S_POP: begin
					top_q <= stk_rd_q;
				end
				tsam_pkg::S_OUT: begin
					if (out_acc) begin
						if (is_last) begin
							visited_q <= '0;
							row_vld_q <= '0;
							k_q       <= '0;
						end else begin
							k_q <= k_q + VW'(1);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// -------------------------------------------------------------- memories
	// rows not written since the last clear read as zero via row_vld_q
	always_ff @(posedge clk) begin
		if (adj_we) begin
			if (row_vld_q[from_idx]) begin
				adj_mem[from_idx][to_idx] <= 1'b1;
			end else begin
				adj_mem[from_idx] <= to_oh;
			end
		end
		adj_rd_q     <= adj_mem[top_q];
		adj_rd_vld_q <= row_vld_q[top_q];
	end

	// stack memory holds every entry below the top; top lives in top_q
	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[VW'(depth_q - CW'(1))] <= top_q;
		end
		stk_rd_q <= stk_mem[VW'(depth_q - CW'(2))];
	end

	always_ff @(posedge clk) begin
		if (ord_we) begin
			ord_mem[VW'(fill_q - CW'(1))] <= top_q;
		end
		ord_rd_q <= ord_mem[k_q];
	end

`ifndef SYNTHESIS
	// the search must be fully unwound before results go out
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (depth_q == '0))
		else $error("result shown with search stack not empty");

	// every vertex of the graph must have been placed before emitting
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (fill_q == '0))
		else $error("result shown with order store not full");

	// delivering the final vertex returns the block to edge loading
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last_of_order) |=> !in_stall)
		else $error("not back to loading after final vertex");
`endif

endmodule

### test/tb_topo_sort_adjacency_matrix_unit.sv
// ----------------------------------------------------------------------------
// tb_topo_sort_adjacency_matrix_unit
// Self-checking bench for the adjacency-matrix topological sort unit.
// ----------------------------------------------------------------------------
// Graphs are loaded edge by edge and closed with an equal-vertex pair. A
// scoreboard keeps its own matrix and vertex count, runs the same
// depth-first search on every closing transaction and checks the emitted
// order vertex by vertex. A short directed part covers the count extremes,
// ignored edges, cycles and out-of-range closing pairs; random graphs follow
// with random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_topo_sort_adjacency_matrix_unit;

	localparam int NV = 32;
	localparam int ITEM_TARGET = 420;
	localparam int CYCLE_LIMIT = 4000000;

	typedef struct packed {
		logic [tsam_pkg::VID_W-1:0] vertex;
		logic                       is_last;
	} order_item_t;

	class topo_scoreboard;
		logic [NV-1:0]             adjacency [NV];
		logic [tsam_pkg::VC_W-1:0] count_reg;
		order_item_t               expected_order[$];
		int                        errors;
		int                        inputs_seen;
		int                        edges_kept;
		int                        orders_done;
		int                        results_checked;
		int                        count_writes;

		function new();
			for (int r = 0; r < NV; r++) adjacency[r] = '0;
			count_reg = tsam_pkg::VC_RESET;
			errors = 0;
			inputs_seen = 0;
			edges_kept = 0;
			orders_done = 0;
			results_checked = 0;
			count_writes = 0;
		endfunction

		function void set_count(logic [tsam_pkg::VC_W-1:0] v);
			count_reg = v;
			count_writes++;
		endfunction

		// 0 reads as 1, anything above the matrix size as the matrix size
		function int active_count();
			if (count_reg == 0) return 1;
			if (count_reg > NV) return NV;
			return int'(count_reg);
		endfunction

		// depth-first search, finished vertices fill the order from the top
		function void build_order(int n);
			logic [NV-1:0] seen;
			int            stk[NV];
			int            slot[NV];
			int            depth;
			int            fill;
			int            r;
			int            nb;
			order_item_t   item;
			seen = '0;
			fill = n;
			for (int root = 0; root < n; root++) begin
				if (seen[root]) continue;
				seen[root] = 1'b1;
				stk[0] = root;
				depth = 1;
				while (depth > 0) begin
					r = stk[depth-1];
					nb = n;
					for (int c = 0; c < n; c++) begin
						if (adjacency[r][c] && !seen[c]) begin
							nb = c;
							break;
						end
					end
					if (nb < n) begin
						seen[nb] = 1'b1;
						stk[depth] = nb;
						depth++;
					end else begin
						depth--;
						fill--;
						slot[fill] = r;
					end
				end
			end
			for (int k = 0; k < n; k++) begin
				item.vertex = slot[k][tsam_pkg::VID_W-1:0];
				item.is_last = (k == n - 1);
				expected_order.push_back(item);
			end
		endfunction

		function void note_input(logic [tsam_pkg::VID_W-1:0] f, logic [tsam_pkg::VID_W-1:0] t);
			int n;
			n = active_count();
			inputs_seen++;
			if (f != t) begin
				if (f < n && t < n) begin
					adjacency[f][t] = 1'b1;
					edges_kept++;
				end
				return;
			end
			build_order(n);
			orders_done++;
			for (int r = 0; r < NV; r++) adjacency[r] = '0;
		endfunction

		function void check_result(logic [tsam_pkg::VID_W-1:0] v, logic is_last);
			order_item_t want;
			if (expected_order.size() == 0) begin
				$error("unexpected result: vertex %0d last %0b", v, is_last);
				errors++;
				return;
			end
			want = expected_order.pop_front();
			results_checked++;
			if (v !== want.vertex) begin
				$error("vertex mismatch: expected %0d, got %0d", want.vertex, v);
				errors++;
			end
			if (is_last !== want.is_last) begin
				$error("last_of_order mismatch: expected %0b, got %0b", want.is_last, is_last);
				errors++;
			end
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [tsam_pkg::VC_W-1:0]  cfg_data;
	logic                       in_valid;
	logic                       in_stall;
	logic [tsam_pkg::VID_W-1:0] from_vertex;
	logic [tsam_pkg::VID_W-1:0] to_vertex;
	logic                       out_valid;
	logic                       out_stall;
	logic [tsam_pkg::VID_W-1:0] vertex;
	logic                       last_of_order;

	topo_scoreboard sb;
	bit             quiet;
	int             cycles;

	topo_sort_adjacency_matrix_unit #(
		.MAX_VERTICES(NV)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.from_vertex  (from_vertex),
		.to_vertex    (to_vertex),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.vertex       (vertex),
		.last_of_order(last_of_order)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(vertex, last_of_order);
	end

	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			repeat ($urandom_range(1, 8)) @(posedge clk);
			g = quiet ? 0 : idle_len();
			if (g > 0) begin
				out_stall <= 1'b1;
				repeat (g) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_pair(input logic [tsam_pkg::VID_W-1:0] f,
			input logic [tsam_pkg::VID_W-1:0] t);
		int g;
		in_valid <= 1'b1;
		from_vertex <= f;
		to_vertex <= t;
		do @(posedge clk); while (in_stall);
		sb.note_input(f, t);
		g = quiet ? 0 : idle_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// drain all pending results, then leave room for the unit to clear
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.expected_order.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_count(input logic [tsam_pkg::VC_W-1:0] v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_count(v);
	endtask

	task automatic directed_graphs();
		// full size from reset: a cycle through the extreme ids plus one between ids 1 and 2
		send_pair(5'd0, 5'd31);
		send_pair(5'd31, 5'd30);
		send_pair(5'd30, 5'd0);
		send_pair(5'd1, 5'd2);
		send_pair(5'd2, 5'd1);
		send_pair(5'd31, 5'd31);
		// tiny graph, edges outside it dropped, closed by an out-of-range pair
		write_count(6'd4);
		send_pair(5'd3, 5'd0);
		send_pair(5'd0, 5'd5);
		send_pair(5'd7, 5'd1);
		send_pair(5'd2, 5'd3);
		send_pair(5'd1, 5'd2);
		send_pair(5'd31, 5'd31);
		// zero count acts as a single vertex
		write_count(6'd0);
		send_pair(5'd0, 5'd1);
		send_pair(5'd0, 5'd0);
		// count above the matrix size clamps to it
		write_count(6'd63);
		send_pair(5'd31, 5'd0);
		send_pair(5'd17, 5'd17);
		// count shrinks in the middle of loading
		write_count(6'd8);
		send_pair(5'd6, 5'd7);
		send_pair(5'd0, 5'd6);
		write_count(6'd5);
		send_pair(5'd1, 5'd4);
		send_pair(5'd2, 5'd2);
		write_count(6'd1);
		send_pair(5'd0, 5'd0);
		write_count(6'd32);
	endtask

	function automatic logic [tsam_pkg::VC_W-1:0] pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) return 6'd0;
		if (r < 16) return 6'd1;
		if (r < 30) return 6'd32;
		if (r < 38) return 6'($urandom_range(33, 63));
		if (r < 78) return 6'($urandom_range(2, 8));
		return 6'($urandom_range(9, 31));
	endfunction

	task automatic random_graph();
		int n;
		int ne;
		int a;
		int b;
		int j;
		int tmp;
		int r;
		int perm[NV];
		logic [tsam_pkg::VID_W-1:0] f;
		logic [tsam_pkg::VID_W-1:0] t;
		quiet = ($urandom_range(0, 99) < 20);
		if ($urandom_range(0, 99) < 40) write_count(pick_count());
		n = sb.active_count();
		for (int i = 0; i < NV; i++) perm[i] = i;
		for (int i = n - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = perm[i];
			perm[i] = perm[j];
			perm[j] = tmp;
		end
		ne = $urandom_range(0, (n < 4) ? 4 : 2 * n);
		if (ne > 48) ne = 48;
		for (int e = 0; e < ne; e++) begin
			if (e == ne / 2 && $urandom_range(0, 99) < 8) write_count(pick_count());
			r = $urandom_range(0, 99);
			if (r < 75 && n >= 2) begin
				// forward edge along a hidden order
				a = $urandom_range(0, n - 2);
				b = $urandom_range(a + 1, n - 1);
				f = perm[a][tsam_pkg::VID_W-1:0];
				t = perm[b][tsam_pkg::VID_W-1:0];
			end else if (r < 88 && n >= 2) begin
				// any in-range edge, cycles allowed
				a = $urandom_range(0, n - 1);
				b = $urandom_range(0, n - 2);
				if (b >= a) b++;
				f = a[tsam_pkg::VID_W-1:0];
				t = b[tsam_pkg::VID_W-1:0];
			end else begin
				f = 5'($urandom_range(0, 31));
				t = 5'($urandom_range(0, 31));
				if (t == f) t = f ^ 5'd1;
			end
			send_pair(f, t);
		end
		f = 5'($urandom_range(0, 31));
		send_pair(f, f);
	endtask

	initial begin
		sb = new();
		quiet = 1'b0;
		cycles = 0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		from_vertex = '0;
		to_vertex = '0;
		out_stall = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_graphs();
		while (sb.inputs_seen < ITEM_TARGET) random_graph();
		quiet = 1'b0;
		in_valid <= 1'b0;
		while (sb.expected_order.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("covered %0d graphs, %0d stored edges, %0d vertices checked",
			sb.orders_done, sb.edges_kept, sb.results_checked);
		$display("%0d vertex count writes, %0d cycles", sb.count_writes, cycles);
		if (sb.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

### sim.f
hw/rtl/tsam_pkg.sv
hw/rtl/tsam_pick.sv
hw/rtl/topo_sort_adjacency_matrix_unit.sv
test/tb_topo_sort_adjacency_matrix_unit.sv
